/* hdl/drrm_pkg.sv */
// Shared types and constants of the dual sensor rotation rate meter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package drrm_pkg;

  // Rate and timeout constants
  localparam logic [15:0] RATE_NUM   = 16'd60000;
  localparam logic [39:0] TIMEOUT_MS = 40'd60000;

  // Register map: index taken from paddr bit 2
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_PULSE_FACTOR  = 1'b0;
  localparam logic REG_TIMEOUT_RATIO = 1'b1;

  // Item queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider retires two quotient bits a cycle; counts are double steps minus one
  localparam logic [3:0] DIV_CNT_NARROW = 4'd7;
  localparam logic [3:0] DIV_CNT_WIDE   = 4'd15;

  // Classified sample
  typedef struct packed {
    logic        pulse;
    logic [31:0] now_ms;
  } drrm_item_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic        wide;
    logic [31:0] num;
    logic [31:0] den;
  } drrm_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } drrm_div_resp_t;

  // Back-end sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RATE  = 7'b0000010,
    ST_SHOWN = 7'b0000100,
    ST_REV   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } drrm_state_e;

endpackage

/* hdl/drrm_queue.sv */
// Short item queue that decouples the front classifier from the back sequencer.
// Depends on drrm_pkg for the item type and depth.
`timescale 1ns / 1ps

module drrm_queue import drrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  drrm_item_t wdata_i,
  output logic       full_o,
  input  logic       rd_i,
  output drrm_item_t rdata_o,
  output logic       empty_o
);

  drrm_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wptr_q;
  logic [QPTR_W-1:0]      rptr_q;
  logic [QCNT_W-1:0]      cnt_q;
  logic                   do_wr;
  logic                   do_rd;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Store written items
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* hdl/drrm_front.sv */
// Front end: accepts sensor samples, tracks the arm flag and tags counted pulses.
// Depends on drrm_pkg for the item type.
`timescale 1ns / 1ps

module drrm_front import drrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic       sensor_a_i,
  input  logic       sensor_b_i,
  input  logic [31:0] now_ms_i,
  output logic       wr_o,
  output drrm_item_t item_o
);

  logic armed_q;
  logic armed_d;
  logic take;
  logic both_high;
  logic both_low;

  assign take      = push_i && !full_i;
  assign both_high = sensor_a_i && sensor_b_i;
  assign both_low  = !sensor_a_i && !sensor_b_i;

  // Classify the sample: both low while disarmed counts one pulse
  assign item_o.pulse  = both_low && !armed_q;
  assign item_o.now_ms = now_ms_i;
  assign wr_o          = take;

  // Update the arm flag
  always_comb begin
    armed_d = armed_q;
    if (take) begin
      if (both_high && armed_q) begin
        armed_d = 1'b0;
      end else if (item_o.pulse) begin
        armed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
    end
  end

  // A counted pulse always leaves the flag armed
  a_pulse_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_o.pulse |=> armed_q)
    else $error("pulse did not arm");

endmodule

/* hdl/drrm_div.sv */
// Iterative restoring divider, two quotient bits per cycle, 16 or 32 bit dividend.
// Depends on drrm_pkg for the request and response types.
`timescale 1ns / 1ps

module drrm_div import drrm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  drrm_div_req_t  req_i,
  output drrm_div_resp_t resp_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [32:0] step1;
  logic [32:0] step2;

  // One restoring step: returns {remainder, quotient bit}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                           input logic [31:0] den);
    logic [32:0] trial;
    logic [32:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      div_step = {diff[31:0], 1'b1};
    end else begin
      div_step = {trial[31:0], 1'b0};
    end
  endfunction

  assign step1 = div_step(rem_q, quo_q[31], den_q);
  assign step2 = div_step(step1[32:1], quo_q[30], den_q);

  assign resp_o.done = done_q;
  assign resp_o.quot = quo_q;

  // Control: load on start, count down double steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.wide ? DIV_CNT_WIDE : DIV_CNT_NARROW;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend in, quotient bits out
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.wide ? req_i.num : {req_i.num[15:0], 16'd0};
    end else if (busy_q) begin
      rem_q <= step2[32:1];
      quo_q <= {quo_q[29:0], step1[0], step2[0]};
    end
  end

  // A new division is never launched on top of a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

endmodule

/* hdl/drrm_back.sv */
// Back end: sequences rate, shown rate and revolution divisions, the timeout check
// and the result register. Depends on drrm_pkg and drives a drrm_div instance.
`timescale 1ns / 1ps

module drrm_back import drrm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  drrm_item_t     q_head_i,
  output logic           q_pop_o,
  output drrm_div_req_t  div_req_o,
  input  drrm_div_resp_t div_resp_i,
  input  logic [7:0]     pulse_factor_i,
  input  logic [7:0]     timeout_ratio_i,
  input  logic           pop_i,
  output logic           empty_o,
  output logic           pulse_counted_o,
  output logic [15:0]    pulses_per_minute_o,
  output logic [15:0]    shown_per_minute_o,
  output logic [31:0]    revolutions_o,
  output logic [31:0]    pulse_total_o
);

  drrm_state_e state_q, state_d;
  logic        pulse_q, pulse_d;
  logic [31:0] now_q, now_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [15:0] raw_q, raw_d;
  logic [15:0] shown_q, shown_d;
  logic [31:0] rev_q, rev_d;
  logic [31:0] pcount_q, pcount_d;
  logic [31:0] start_q, start_d;
  logic [39:0] prod_q, prod_d;
  logic        out_valid_q;
  logic        load_out;
  logic [7:0]  factor;
  logic [31:0] head_elapsed;
  logic        head_late;

  // Zero factor acts as one
  assign factor       = (pulse_factor_i == '0) ? 8'd1 : pulse_factor_i;
  assign head_elapsed = q_head_i.now_ms - start_q;
  assign head_late    = q_head_i.now_ms > start_q;
  assign empty_o      = !out_valid_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    pulse_d   = pulse_q;
    now_d     = now_q;
    elapsed_d = elapsed_q;
    raw_d     = raw_q;
    shown_d   = shown_q;
    rev_d     = rev_q;
    pcount_d  = pcount_q;
    start_d   = start_q;
    prod_d    = prod_q;
    q_pop_o   = 1'b0;
    load_out  = 1'b0;
    div_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          pulse_d   = q_head_i.pulse;
          now_d     = q_head_i.now_ms;
          elapsed_d = head_elapsed;
          if (q_head_i.pulse) begin
            pcount_d = pcount_q + 32'd1;
            if (head_late) begin
              div_req_o = '{start: 1'b1, wide: 1'b0, num: {16'd0, RATE_NUM},
                            den: head_elapsed};
              state_d   = ST_RATE;
            end else begin
              div_req_o = '{start: 1'b1, wide: 1'b0, num: {16'd0, raw_q},
                            den: {24'd0, factor}};
              state_d   = ST_SHOWN;
            end
          end else begin
            state_d = head_late ? ST_MUL : ST_DONE;
          end
        end
      end
      ST_RATE: begin
        if (div_resp_i.done) begin
          raw_d     = div_resp_i.quot[15:0];
          start_d   = now_q;
          div_req_o = '{start: 1'b1, wide: 1'b0, num: {16'd0, div_resp_i.quot[15:0]},
                        den: {24'd0, factor}};
          state_d   = ST_SHOWN;
        end
      end
      ST_SHOWN: begin
        if (div_resp_i.done) begin
          shown_d   = div_resp_i.quot[15:0];
          div_req_o = '{start: 1'b1, wide: 1'b1, num: pcount_q, den: {24'd0, factor}};
          state_d   = ST_REV;
        end
      end
      ST_REV: begin
        if (div_resp_i.done) begin
          rev_d   = div_resp_i.quot;
          state_d = ST_DONE;
        end
      end
      ST_MUL: begin
        prod_d  = 40'(elapsed_q) * 40'(timeout_ratio_i);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (prod_q > TIMEOUT_MS) begin
          raw_d   = '0;
          shown_d = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      raw_q       <= '0;
      shown_q     <= '0;
      rev_q       <= '0;
      pcount_q    <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      raw_q    <= raw_d;
      shown_q  <= shown_d;
      rev_q    <= rev_d;
      pcount_q <= pcount_d;
      start_q  <= start_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    pulse_q   <= pulse_d;
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    prod_q    <= prod_d;
    if (load_out) begin
      pulse_counted_o     <= pulse_q;
      pulses_per_minute_o <= raw_q;
      shown_per_minute_o  <= shown_q;
      revolutions_o       <= rev_q;
      pulse_total_o       <= pcount_q;
    end
  end

  // Raw rate never exceeds the one-millisecond rate
  a_raw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_q <= RATE_NUM)
    else $error("raw rate out of range");

  // A taken pulse bumps the pulse count by exactly one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && !q_empty_i && q_head_i.pulse |=>
      pcount_q == $past(pcount_q) + 32'd1)
    else $error("pulse count did not step");

  // A result held but not taken is never overwritten
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |-> !load_out)
    else $error("waiting result overwritten");

endmodule

/* hdl/dual_sensor_rotation_rate_meter.sv */
// Rate meter that counts sensor-gap pulses and reports pulses per minute.
// A counted pulse whose timestamp lies past the period start runs three divisions on one
// shared divider retiring two quotient bits a cycle; a counted pulse with a stale
// timestamp skips the first division, and other samples with a timestamp past the period
// start go through the timeout multiply and compare. A two-entry queue behind the sample
// port and one result register let both sides stall independently.
// Registers: pulse_factor at 0x0, timeout_ratio at 0x4; zero pulse_factor acts as one.
// Depends on drrm_pkg, drrm_front, drrm_queue, drrm_div and drrm_back.
`timescale 1ns / 1ps

module dual_sensor_rotation_rate_meter import drrm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Sample input
  input  logic               push,
  output logic               full,
  input  logic               sensor_a_i,
  input  logic               sensor_b_i,
  input  logic [31:0]        now_ms_i,
  // Result output
  output logic               empty,
  input  logic               pop,
  output logic               pulse_counted_o,
  output logic [15:0]        pulses_per_minute_o,
  output logic [15:0]        shown_per_minute_o,
  output logic [31:0]        revolutions_o,
  output logic [31:0]        pulse_total_o
);

  logic           [7:0] pulse_factor_q;
  logic           [7:0] timeout_ratio_q;
  logic                 cfg_wr;
  logic                 q_wr;
  drrm_item_t           q_wdata;
  logic                 q_rd;
  drrm_item_t           q_head;
  logic                 q_empty;
  drrm_div_req_t        div_req;
  drrm_div_resp_t       div_resp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_factor_q  <= 8'd1;
      timeout_ratio_q <= 8'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PULSE_FACTOR:  pulse_factor_q  <= pwdata[7:0];
        REG_TIMEOUT_RATIO: timeout_ratio_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_PULSE_FACTOR:  prdata = {24'd0, pulse_factor_q};
      REG_TIMEOUT_RATIO: prdata = {24'd0, timeout_ratio_q};
      default:           prdata = '0;
    endcase
  end

  drrm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .sensor_a_i (sensor_a_i),
    .sensor_b_i (sensor_b_i),
    .now_ms_i   (now_ms_i),
    .wr_o       (q_wr),
    .item_o     (q_wdata)
  );

  drrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  drrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  drrm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_empty),
    .q_head_i            (q_head),
    .q_pop_o             (q_rd),
    .div_req_o           (div_req),
    .div_resp_i          (div_resp),
    .pulse_factor_i      (pulse_factor_q),
    .timeout_ratio_i     (timeout_ratio_q),
    .pop_i               (pop),
    .empty_o             (empty),
    .pulse_counted_o     (pulse_counted_o),
    .pulses_per_minute_o (pulses_per_minute_o),
    .shown_per_minute_o  (shown_per_minute_o),
    .revolutions_o       (revolutions_o),
    .pulse_total_o       (pulse_total_o)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the dual sensor rotation rate meter: directed samples, then random
// sample streams under several register settings and handshake idling patterns.
// Depends on drrm_pkg and dual_sensor_rotation_rate_meter.
`timescale 1ns / 1ps

module tb_top;
  import drrm_pkg::*;

  localparam int unsigned RATE_PER_MINUTE  = 60000;
  localparam logic [39:0] TIMEOUT_LIMIT_MS = 40'd60000;
  localparam int unsigned SETTLE_CYCLES    = 50;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS      = 230;

  localparam logic [PADDR_W-1:0] ADDR_PULSE_FACTOR  = {REG_PULSE_FACTOR, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_TIMEOUT_RATIO = {REG_TIMEOUT_RATIO, 2'b00};

  typedef struct packed {
    logic        pulse_counted;
    logic [15:0] pulses_per_minute;
    logic [15:0] shown_per_minute;
    logic [31:0] revolutions;
    logic [31:0] pulse_total;
  } meter_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic        push = 1'b0;
  logic        full;
  logic        sensor_a_i = 1'b0;
  logic        sensor_b_i = 1'b0;
  logic [31:0] now_ms_i = '0;

  logic        empty;
  logic        pop = 1'b0;
  logic        pulse_counted_o;
  logic [15:0] pulses_per_minute_o;
  logic [15:0] shown_per_minute_o;
  logic [31:0] revolutions_o;
  logic [31:0] pulse_total_o;

  // Predicted meter state and register copies
  logic        meter_armed;
  logic [31:0] meter_pulses;
  logic [31:0] meter_start_ms;
  logic [15:0] meter_raw_rate;
  logic [15:0] meter_shown_rate;
  logic [31:0] meter_revs;
  logic [7:0]  cfg_pulse_factor;
  logic [7:0]  cfg_timeout_ratio;

  meter_result_t pending_results[$];
  meter_result_t oldest_result;
  int unsigned   mismatch_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  logic [31:0]   clock_ms;

  dual_sensor_rotation_rate_meter u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .push               (push),
    .full               (full),
    .sensor_a_i         (sensor_a_i),
    .sensor_b_i         (sensor_b_i),
    .now_ms_i           (now_ms_i),
    .empty              (empty),
    .pop                (pop),
    .pulse_counted_o    (pulse_counted_o),
    .pulses_per_minute_o(pulses_per_minute_o),
    .shown_per_minute_o (shown_per_minute_o),
    .revolutions_o      (revolutions_o),
    .pulse_total_o      (pulse_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the predicted meter by one sample and return the outputs it should show
  function automatic meter_result_t advance_meter(input logic a, input logic b,
                                                  input logic [31:0] stamp);
    meter_result_t res;
    logic [31:0]   divisor;
    logic [39:0]   weighted;
    res = '0;
    divisor = (cfg_pulse_factor == 8'd0) ? 32'd1 : {24'd0, cfg_pulse_factor};
    if (a && b && meter_armed) begin
      meter_armed = 1'b0;
    end else if (!a && !b && !meter_armed) begin
      meter_armed = 1'b1;
      res.pulse_counted = 1'b1;
      meter_pulses = meter_pulses + 32'd1;
      if (stamp > meter_start_ms) begin
        meter_raw_rate = 16'(RATE_PER_MINUTE / (stamp - meter_start_ms));
        meter_start_ms = stamp;
      end
      meter_shown_rate = 16'({16'd0, meter_raw_rate} / divisor);
      meter_revs = meter_pulses / divisor;
    end
    // Rates drop once the weighted gap since the period start runs too long
    if (stamp > meter_start_ms) begin
      weighted = 40'(stamp - meter_start_ms) * 40'(cfg_timeout_ratio);
      if (weighted > TIMEOUT_LIMIT_MS) begin
        meter_raw_rate = '0;
        meter_shown_rate = '0;
      end
    end
    res.pulses_per_minute = meter_raw_rate;
    res.shown_per_minute = meter_shown_rate;
    res.revolutions = meter_revs;
    res.pulse_total = meter_pulses;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Check each popped result against the oldest prediction; randomize pop for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with none pending", 0, 1);
      end else begin
        oldest_result = pending_results.pop_front();
        if (pulse_counted_o !== oldest_result.pulse_counted)
          note_mismatch("pulse_counted", oldest_result.pulse_counted, pulse_counted_o);
        if (pulses_per_minute_o !== oldest_result.pulses_per_minute)
          note_mismatch("pulses_per_minute", oldest_result.pulses_per_minute,
                        pulses_per_minute_o);
        if (shown_per_minute_o !== oldest_result.shown_per_minute)
          note_mismatch("shown_per_minute", oldest_result.shown_per_minute,
                        shown_per_minute_o);
        if (revolutions_o !== oldest_result.revolutions)
          note_mismatch("revolutions", oldest_result.revolutions, revolutions_o);
        if (pulse_total_o !== oldest_result.pulse_total)
          note_mismatch("pulse_total", oldest_result.pulse_total, pulse_total_o);
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one sample item, idling first as the sender pattern asks
  task automatic send_sample(input logic a, input logic b, input logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    sensor_a_i <= a;
    sensor_b_i <= b;
    now_ms_i <= stamp;
    do @(posedge clk_i); while (full);
    pending_results.push_back(advance_meter(a, b, stamp));
  endtask

  // Hold off until every pending result is back and the block has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register: setup cycle, access cycle, then the bus goes idle
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (addr == ADDR_PULSE_FACTOR) cfg_pulse_factor = value;
    else cfg_timeout_ratio = value;
  endtask

  task automatic configure(input logic [7:0] factor, input logic [7:0] ratio);
    settle();
    write_reg(ADDR_PULSE_FACTOR, factor);
    write_reg(ADDR_TIMEOUT_RATIO, ratio);
  endtask

  // Arming, counting, rate extremes, timeout edge and stale timestamps at reset settings
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(1'b1, 1'b1, 32'd0);
    send_sample(1'b1, 1'b0, 32'd0);
    send_sample(1'b0, 1'b1, 32'd0);
    send_sample(1'b0, 1'b0, 32'd0);
    send_sample(1'b0, 1'b0, 32'd10);
    send_sample(1'b1, 1'b1, 32'd10);
    send_sample(1'b0, 1'b0, 32'd1);
    send_sample(1'b1, 1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b1, 32'd2);
    send_sample(1'b0, 1'b0, 32'd3);
    send_sample(1'b0, 1'b1, 32'd60003);
    send_sample(1'b1, 1'b1, 32'd60004);
    send_sample(1'b0, 1'b0, 32'd60005);
    send_sample(1'b1, 1'b1, 32'd60005);
    send_sample(1'b0, 1'b0, 32'd2);
    send_sample(1'b1, 1'b1, 32'd2);
    send_sample(1'b0, 1'b0, 32'd120004);
  endtask

  // Factor changes show after a pulse; zero factor acts as one, zero ratio never times out
  task automatic test_register_change();
    configure(8'd0, 8'd0);
    send_sample(1'b1, 1'b0, 32'd120005);
    send_sample(1'b1, 1'b1, 32'd120006);
    send_sample(1'b0, 1'b0, 32'd120010);
    send_sample(1'b1, 1'b1, 32'd9000000);
    configure(8'd255, 8'd255);
    send_sample(1'b1, 1'b0, 32'd120010);
    send_sample(1'b0, 1'b0, 32'd120011);
    send_sample(1'b1, 1'b1, 32'd120246);
    send_sample(1'b1, 1'b1, 32'd120247);
  endtask

  // Mostly clean low/high pulse trains with random spacing, plus mixed levels and noise
  task automatic test_random_phase(input int unsigned phase);
    logic [7:0]  factor;
    logic [7:0]  ratio;
    logic        go_low;
    logic        a;
    logic        b;
    logic [31:0] stamp;
    int unsigned pick;
    case (phase)
      0: begin factor = 8'd1;   ratio = 8'd1;   end
      1: begin factor = 8'd255; ratio = 8'd255; end
      2: begin factor = 8'd0;   ratio = 8'd0;   end
      3: begin factor = 8'd3;   ratio = 8'd10;  end
      4: begin factor = 8'd7;   ratio = 8'd2;   end
      5: begin factor = 8'd2;   ratio = 8'd100; end
      6: begin factor = 8'($urandom); ratio = 8'($urandom); end
      default: begin factor = 8'd16; ratio = 8'd1; end
    endcase
    configure(factor, ratio);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
    go_low = 1'b1;
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) clock_ms = clock_ms + $urandom_range(0, 20);
      else if (pick < 85) clock_ms = clock_ms + $urandom_range(20, 500);
      else if (pick < 97) clock_ms = clock_ms + $urandom_range(500, 5000);
      else clock_ms = clock_ms + $urandom_range(5000, 100000);
      stamp = clock_ms;
      pick = $urandom_range(99);
      if (pick < 12) begin
        // Mixed levels, now and then with a wild timestamp
        a = 1'($urandom);
        b = ~a;
        if ($urandom_range(9) == 0) stamp = $urandom;
      end else if (pick < 20) begin
        a = 1'($urandom);
        b = 1'($urandom);
      end else begin
        a = ~go_low;
        b = ~go_low;
        if (pick < 23) begin
          // Stale or repeated timestamp
          stamp = (meter_start_ms >= 32'd1000) ?
                  meter_start_ms - $urandom_range(0, 999) : meter_start_ms;
        end
        if ($urandom_range(1) == 1) go_low = ~go_low;
      end
      send_sample(a, b, stamp);
    end
  endtask

  initial begin
    meter_armed = 1'b0;
    meter_pulses = '0;
    meter_start_ms = '0;
    meter_raw_rate = '0;
    meter_shown_rate = '0;
    meter_revs = '0;
    cfg_pulse_factor = 8'd1;
    cfg_timeout_ratio = 8'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_change();
    clock_ms = 32'd200000;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) test_random_phase(p);
    settle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hdl/drrm_pkg.sv
hdl/drrm_queue.sv
hdl/drrm_front.sv
hdl/drrm_div.sv
hdl/drrm_back.sv
hdl/dual_sensor_rotation_rate_meter.sv
bench/tb_top.sv
